// File: rtl/cqe_pkg.sv
// shared types and constants for the circular queue engine
package cqe_pkg;

    // field widths
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned CAP_W   = 7;

    // word returned by a delete on an empty queue (-9999)
    localparam logic [WORD_W-1:0] EMPTY_WORD = 32'hFFFF_D8F1;

    // operation carried in the input tuser
    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT  = 2'd0,
        MODE_DELETE  = 2'd1,
        MODE_DISPLAY = 2'd2,
        MODE_NONE    = 2'd3
    } t_mode;

    // result status carried in the output tuser
    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // what every cell of the chain does in a cycle
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_WRITE  = 2'd1,
        CELL_SHIFT  = 2'd2,
        CELL_ROTATE = 2'd3
    } t_cell_op;

    // control broadcast from the sequencer to the cell chain
    typedef struct packed {
        t_cell_op          op;
        logic [WORD_W-1:0] word;   // word to store on insert
        logic [WORD_W-1:0] head;   // word of cell 0, wrapped to the tail on rotate
    } t_cell_ctrl;

endpackage

// File: rtl/cqe_cell.sv
// one queue cell: holds the word at a fixed distance from the head
module cqe_cell #(
    parameter int unsigned INDEX = 0,
    parameter int unsigned CNT_W = 7
) (
    input  logic                        i_clk,
    input  cqe_pkg::t_cell_ctrl         i_ctrl,
    input  logic [CNT_W-1:0]            i_count,
    input  logic [cqe_pkg::WORD_W-1:0]  i_next,
    output logic [cqe_pkg::WORD_W-1:0]  o_word
);

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

    logic [cqe_pkg::WORD_W-1:0] r_word;
    logic [cqe_pkg::WORD_W-1:0] n_word;
    logic [CNT_W-1:0]           c_tail;

    // position of the youngest stored word
    assign c_tail = i_count - CNT_W'(1);

    // next word: write at the first free slot, shift toward the head, or rotate
    always_comb begin
        n_word = r_word;
        case (i_ctrl.op)
            cqe_pkg::CELL_WRITE: begin
                if (i_count == MY_IDX) n_word = i_ctrl.word;
            end
            cqe_pkg::CELL_SHIFT: begin
                n_word = i_next;
            end
            cqe_pkg::CELL_ROTATE: begin
                n_word = (c_tail == MY_IDX) ? i_ctrl.head : i_next;
            end
            default: begin
                n_word = r_word;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

// File: rtl/circular_queue_engine.sv
// top level: cell chain queue with insert, delete and display sequencing
//
// Input stream (s_axis): tuser carries the mode (insert, delete, display),
// tdata the signed word to insert. Output stream (m_axis): tuser carries the
// status (ok, full, empty), tdata the returned word, tlast marks the final
// result of one input transaction. The config channel writes the capacity;
// a write also empties the queue. It is not taken during a display walk, and
// a pending write holds off the input stream.
// The queue is a row of cells, cell 0 holding the oldest word. Insert writes
// the cell at the fill count, delete shifts every cell one place toward the
// head, display rotates the row once per emitted word so the order is back in
// place after the last one.
// Insert and delete produce a registered result in the cycle after acceptance;
// back-to-back insert/delete run at one transaction per cycle while results are taken.
// Display of n stored words emits one word per rotation step, pausing while the output
// is held; empty display emits a single result. The next transaction is taken after that.
// Reset empties the queue and sets capacity to 64; stored words are not
// cleared. A stalled receiver holds the output register and stops the
// sequencer; s_axis_tready drops until the result is taken.
module circular_queue_engine #(
    parameter int unsigned QUEUE_DEPTH = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [31:0]                 s_axis_tdata,   // [31:0] data_in
    input  logic [7:0]                  s_axis_tuser,   // [1:0] mode
    // output stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [31:0]                 m_axis_tdata,   // [31:0] data_out
    output logic [7:0]                  m_axis_tuser,   // [1:0] status
    output logic                        m_axis_tlast,
    // capacity register write
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [7:0]                  i_cfg_data      // [6:0] capacity
);

    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned EFF_W = (CNT_W > cqe_pkg::CAP_W) ? CNT_W : cqe_pkg::CAP_W;
    localparam logic [EFF_W-1:0] DEPTH_E = EFF_W'(QUEUE_DEPTH);

    // control and output registers
    logic [CNT_W-1:0]             r_count, n_count;
    logic [CNT_W-1:0]             r_left, n_left;
    logic                         r_busy, n_busy;
    logic [cqe_pkg::CAP_W-1:0]    r_cap, n_cap;
    logic                         r_out_valid, n_out_valid;
    cqe_pkg::t_status             r_status, n_status;
    logic [cqe_pkg::WORD_W-1:0]   r_data, n_data;
    logic                         r_last, n_last;

    logic                         c_out_free;
    logic                         c_accept;
    logic                         c_cfg_we;
    logic [EFF_W-1:0]             c_cap_e;
    logic [EFF_W-1:0]             c_eff_cap;
    logic                         c_full;
    cqe_pkg::t_mode               c_mode;
    cqe_pkg::t_cell_ctrl          c_ctrl;
    logic [cqe_pkg::WORD_W-1:0]   c_word [QUEUE_DEPTH];

    // handshakes
    assign c_out_free    = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_busy && c_out_free && !i_cfg_valid;
    assign c_accept      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = !r_busy;
    assign c_cfg_we      = i_cfg_valid && o_cfg_ready;
    assign c_mode        = cqe_pkg::t_mode'(s_axis_tuser[cqe_pkg::MODE_W-1:0]);

    // effective capacity: zero acts as one, clipped to the cell count
    assign c_cap_e   = EFF_W'(r_cap);
    assign c_eff_cap = (c_cap_e == '0) ? EFF_W'(1) :
                       (c_cap_e > DEPTH_E) ? DEPTH_E : c_cap_e;
    assign c_full    = EFF_W'(r_count) >= c_eff_cap;

    // cell chain
    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            logic [cqe_pkg::WORD_W-1:0] c_next;
            if (g == QUEUE_DEPTH - 1) begin : g_end
                assign c_next = c_word[g];
            end else begin : g_mid
                assign c_next = c_word[g+1];
            end
            cqe_cell #(
                .INDEX (g),
                .CNT_W (CNT_W)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (c_ctrl),
                .i_count (r_count),
                .i_next  (c_next),
                .o_word  (c_word[g])
            );
        end
    endgenerate

    // sequencer next state
    always_comb begin
        n_count     = r_count;
        n_left      = r_left;
        n_busy      = r_busy;
        n_cap       = r_cap;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_status    = r_status;
        n_data      = r_data;
        n_last      = r_last;
        c_ctrl.op   = cqe_pkg::CELL_HOLD;
        c_ctrl.word = s_axis_tdata;
        c_ctrl.head = c_word[0];

        if (c_cfg_we) begin
            n_cap   = i_cfg_data[cqe_pkg::CAP_W-1:0];
            n_count = '0;
            n_busy  = 1'b0;
        end else if (r_busy) begin
            // display walk: emit the head and rotate
            if (c_out_free) begin
                c_ctrl.op   = cqe_pkg::CELL_ROTATE;
                n_out_valid = 1'b1;
                n_status    = cqe_pkg::ST_OK;
                n_data      = c_word[0];
                n_last      = (r_left == CNT_W'(1));
                n_left      = r_left - CNT_W'(1);
                if (r_left == CNT_W'(1)) n_busy = 1'b0;
            end
        end else if (c_accept) begin
            case (c_mode)
                cqe_pkg::MODE_INSERT: begin
                    n_out_valid = 1'b1;
                    n_data      = '0;
                    n_last      = 1'b1;
                    if (c_full) begin
                        n_status = cqe_pkg::ST_FULL;
                    end else begin
                        c_ctrl.op = cqe_pkg::CELL_WRITE;
                        n_count   = r_count + CNT_W'(1);
                        n_status  = cqe_pkg::ST_OK;
                    end
                end
                cqe_pkg::MODE_DELETE: begin
                    n_out_valid = 1'b1;
                    n_last      = 1'b1;
                    if (r_count == '0) begin
                        n_status = cqe_pkg::ST_EMPTY;
                        n_data   = cqe_pkg::EMPTY_WORD;
                    end else begin
                        c_ctrl.op = cqe_pkg::CELL_SHIFT;
                        n_count   = r_count - CNT_W'(1);
                        n_status  = cqe_pkg::ST_OK;
                        n_data    = c_word[0];
                    end
                end
                cqe_pkg::MODE_DISPLAY: begin
                    n_out_valid = 1'b1;
                    if (r_count == '0) begin
                        n_status = cqe_pkg::ST_EMPTY;
                        n_data   = '0;
                        n_last   = 1'b1;
                    end else begin
                        c_ctrl.op = cqe_pkg::CELL_ROTATE;
                        n_status  = cqe_pkg::ST_OK;
                        n_data    = c_word[0];
                        n_last    = (r_count == CNT_W'(1));
                        n_left    = r_count - CNT_W'(1);
                        n_busy    = (r_count != CNT_W'(1));
                    end
                end
                default: begin
                    // unused mode: no result, no state change
                    n_out_valid = r_out_valid && !m_axis_tready;
                end
            endcase
        end
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_left      <= '0;
            r_busy      <= 1'b0;
            r_cap       <= cqe_pkg::CAP_W'(64);
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_left      <= n_left;
            r_busy      <= n_busy;
            r_cap       <= n_cap;
            r_out_valid <= n_out_valid;
        end
        r_status <= n_status;
        r_data   <= n_data;
        r_last   <= n_last;
    end

    // output stream
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_data;
    assign m_axis_tuser  = {{(8 - cqe_pkg::STAT_W){1'b0}}, r_status};
    assign m_axis_tlast  = r_last;

    // fill count never exceeds the cell count
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        EFF_W'(r_count) <= DEPTH_E)
        else $error("fill count beyond queue depth");

    // a display walk only runs over stored words
    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_left != '0) && (r_left < r_count))
        else $error("display walk count out of range");

    // input is never taken during a display walk
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !s_axis_tready)
        else $error("input taken during display walk");

    // a new result is never loaded over one that was not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready && !i_cfg_valid) |=> $stable(r_data))
        else $error("pending result overwritten");

endmodule
